// File: sv/point_affine_transform_2d_assert.svh
// assertion macros for the point affine transform checker
`ifndef POINT_AFFINE_TRANSFORM_2D_ASSERT_SVH
`define POINT_AFFINE_TRANSFORM_2D_ASSERT_SVH

// same-cycle implication
`define PAT2D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pat2d assertion failed");

// next-cycle implication
`define PAT2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pat2d assertion failed");

`endif

// File: sv/pat2d_pkg.sv
// types, codes and width constants for the point affine transform
`timescale 1ns / 1ps

package pat2d_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 12;
  localparam int COEF_BITS  = 16;

  localparam int Q_ONE_INT = 1 << FRAC_BITS;

  localparam int AW = COORD_BITS + 1;
  localparam int BW = (FRAC_BITS + 2 > COEF_BITS + 1) ? FRAC_BITS + 2 : COEF_BITS + 1;
  localparam int PW = AW + BW;
  localparam int SW = PW + 2;
  localparam int TW = SW - FRAC_BITS;

  localparam int TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic signed [TW-1:0] SAT_HI =
    TW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [AW-1:0]         opa_t;
  typedef logic signed [BW-1:0]         opb_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [SW-1:0]         sum_t;
  typedef logic signed [TW-1:0]         trunc_t;

  typedef enum logic [2:0] {
    MODE_TRANSLATE = 3'd0,
    MODE_SCALE     = 3'd1,
    MODE_ROTATE    = 3'd2,
    MODE_REFLECT   = 3'd3,
    MODE_SHEAR     = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REFL_X_AXIS = 3'd0,
    REFL_Y_AXIS = 3'd1,
    REFL_ORIGIN = 3'd2,
    REFL_SWAP   = 3'd3,
    REFL_NONE   = 3'd4
  } refl_t;

  typedef enum logic [1:0] {
    SHEAR_X    = 2'd0,
    SHEAR_Y    = 2'd1,
    SHEAR_NONE = 2'd2
  } shear_t;

  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_ANCHOR_X     = 3'd1,
    REG_ANCHOR_Y     = 3'd2,
    REG_COEF_X       = 3'd3,
    REG_COEF_Y       = 3'd4,
    REG_REFLECT_AXIS = 3'd5,
    REG_SHEAR_AXIS   = 3'd6
  } reg_idx_t;

  // per coordinate: base + a0*b0 + a1*b1, base in integer units
  typedef struct packed {
    opa_t a0;
    opb_t b0;
    opa_t a1;
    opb_t b1;
    opa_t base;
  } lane_ops_t;

endpackage

// File: sv/point_affine_transform_2d.sv
// 2d affine point transform: pipelined datapath with apb register file
`timescale 1ns / 1ps
// Usage
// - input stream: in_tdata carries one vertex per transaction, x in the low
//   coordinate field and y above it
// - output stream: out_tdata carries the transformed vertex in the same
//   layout, out_tuser is the clipped flag (either coordinate saturated)
// - apb port: mode, anchor_x, anchor_y, coef_x, coef_y, reflect_axis and
//   shear_axis at byte addresses 0, 4, ... 24; write only while idle
// - stages: the operand, multiply, sum and truncate/saturate registers lie
//   between an input transaction and output valid
// - throughput: one vertex per cycle while the output is not stalled; the
//   two multipliers per coordinate are registered in their own stage
// - stall: all stages advance together when the output register is empty
//   or being taken, so in_tready falls only while out_tvalid is held
//   without out_tready; nothing is dropped or repeated
// - reset: valid bits clear and the registers return to translate with
//   zero anchors, coef_x one, coef_y zero, no reflect and no shear
module point_affine_transform_2d (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pat2d_pkg::TDATA_BITS-1:0]      in_tdata,   // in_x, in_y
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pat2d_pkg::TDATA_BITS-1:0]      out_tdata,  // out_x, out_y
  output logic                                  out_tuser,  // clipped
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [pat2d_pkg::ADDR_BITS-1:0]       cfg_paddr,
  input  logic [pat2d_pkg::DATA_BITS-1:0]       cfg_pwdata,
  output logic [pat2d_pkg::DATA_BITS-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int C = pat2d_pkg::COORD_BITS;
  localparam int F = pat2d_pkg::FRAC_BITS;

  pat2d_pkg::mode_t    mode_r;
  pat2d_pkg::coord_t   anchor_x_r;
  pat2d_pkg::coord_t   anchor_y_r;
  pat2d_pkg::coef_t    coef_x_r;
  pat2d_pkg::coef_t    coef_y_r;
  pat2d_pkg::refl_t    reflect_axis_r;
  pat2d_pkg::shear_t   shear_axis_r;

  logic                cfg_wr;
  pat2d_pkg::reg_idx_t cfg_idx;

  logic                adv;
  pat2d_pkg::coord_t   in_x;
  pat2d_pkg::coord_t   in_y;
  pat2d_pkg::lane_ops_t ops_x_nxt;
  pat2d_pkg::lane_ops_t ops_y_nxt;

  logic                 s1_valid_r;
  pat2d_pkg::lane_ops_t s1_ops_x_r;
  pat2d_pkg::lane_ops_t s1_ops_y_r;

  logic                 s2_valid_r;
  pat2d_pkg::prod_t     s2_px0_r;
  pat2d_pkg::prod_t     s2_px1_r;
  pat2d_pkg::prod_t     s2_py0_r;
  pat2d_pkg::prod_t     s2_py1_r;
  pat2d_pkg::opa_t      s2_base_x_r;
  pat2d_pkg::opa_t      s2_base_y_r;

  logic                 s3_valid_r;
  pat2d_pkg::sum_t      s3_sum_x_r;
  pat2d_pkg::sum_t      s3_sum_y_r;

  pat2d_pkg::trunc_t    trunc_x;
  pat2d_pkg::trunc_t    trunc_y;
  pat2d_pkg::coord_t    sat_x;
  pat2d_pkg::coord_t    sat_y;
  logic                 clip_x;
  logic                 clip_y;

  logic                 out_valid_r;
  pat2d_pkg::coord_t    out_x_r;
  pat2d_pkg::coord_t    out_y_r;
  logic                 out_clip_r;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = pat2d_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= pat2d_pkg::MODE_TRANSLATE;
      anchor_x_r     <= '0;
      anchor_y_r     <= '0;
      coef_x_r       <= pat2d_pkg::COEF_BITS'(pat2d_pkg::Q_ONE_INT);
      coef_y_r       <= '0;
      reflect_axis_r <= pat2d_pkg::REFL_NONE;
      shear_axis_r   <= pat2d_pkg::SHEAR_NONE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pat2d_pkg::REG_MODE:         mode_r <= pat2d_pkg::mode_t'(cfg_pwdata[2:0]);
        pat2d_pkg::REG_ANCHOR_X:     anchor_x_r <= cfg_pwdata[C-1:0];
        pat2d_pkg::REG_ANCHOR_Y:     anchor_y_r <= cfg_pwdata[C-1:0];
        pat2d_pkg::REG_COEF_X:       coef_x_r <= cfg_pwdata[pat2d_pkg::COEF_BITS-1:0];
        pat2d_pkg::REG_COEF_Y:       coef_y_r <= cfg_pwdata[pat2d_pkg::COEF_BITS-1:0];
        pat2d_pkg::REG_REFLECT_AXIS: reflect_axis_r <= pat2d_pkg::refl_t'(cfg_pwdata[2:0]);
        pat2d_pkg::REG_SHEAR_AXIS:   shear_axis_r <= pat2d_pkg::shear_t'(cfg_pwdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      pat2d_pkg::REG_MODE:         cfg_prdata = pat2d_pkg::DATA_BITS'(mode_r);
      pat2d_pkg::REG_ANCHOR_X:     cfg_prdata = pat2d_pkg::DATA_BITS'($unsigned(anchor_x_r));
      pat2d_pkg::REG_ANCHOR_Y:     cfg_prdata = pat2d_pkg::DATA_BITS'($unsigned(anchor_y_r));
      pat2d_pkg::REG_COEF_X:       cfg_prdata = pat2d_pkg::DATA_BITS'($unsigned(coef_x_r));
      pat2d_pkg::REG_COEF_Y:       cfg_prdata = pat2d_pkg::DATA_BITS'($unsigned(coef_y_r));
      pat2d_pkg::REG_REFLECT_AXIS: cfg_prdata = pat2d_pkg::DATA_BITS'(reflect_axis_r);
      pat2d_pkg::REG_SHEAR_AXIS:   cfg_prdata = pat2d_pkg::DATA_BITS'(shear_axis_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // pipeline advance
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign in_x = in_tdata[C-1:0];
  assign in_y = in_tdata[2*C-1:C];

  // stage 1: operand selection
  always_comb begin
    ops_x_nxt = '{a0: '0, b0: '0, a1: '0, b1: '0, base: pat2d_pkg::AW'(in_x)};
    ops_y_nxt = '{a0: '0, b0: '0, a1: '0, b1: '0, base: pat2d_pkg::AW'(in_y)};
    unique case (mode_r)
      pat2d_pkg::MODE_TRANSLATE: begin
        ops_x_nxt.base = pat2d_pkg::AW'(in_x) + pat2d_pkg::AW'(anchor_x_r);
        ops_y_nxt.base = pat2d_pkg::AW'(in_y) + pat2d_pkg::AW'(anchor_y_r);
      end
      pat2d_pkg::MODE_SCALE: begin
        ops_x_nxt.base = '0;
        ops_x_nxt.a0   = pat2d_pkg::AW'(in_x);
        ops_x_nxt.b0   = pat2d_pkg::BW'(coef_x_r);
        ops_x_nxt.a1   = pat2d_pkg::AW'(anchor_x_r);
        ops_x_nxt.b1   = pat2d_pkg::BW'(pat2d_pkg::Q_ONE_INT) - pat2d_pkg::BW'(coef_x_r);
        ops_y_nxt.base = '0;
        ops_y_nxt.a0   = pat2d_pkg::AW'(in_y);
        ops_y_nxt.b0   = pat2d_pkg::BW'(coef_y_r);
        ops_y_nxt.a1   = pat2d_pkg::AW'(anchor_y_r);
        ops_y_nxt.b1   = pat2d_pkg::BW'(pat2d_pkg::Q_ONE_INT) - pat2d_pkg::BW'(coef_y_r);
      end
      pat2d_pkg::MODE_ROTATE: begin
        ops_x_nxt.base = pat2d_pkg::AW'(anchor_x_r);
        ops_x_nxt.a0   = pat2d_pkg::AW'(in_x) - pat2d_pkg::AW'(anchor_x_r);
        ops_x_nxt.b0   = pat2d_pkg::BW'(coef_x_r);
        ops_x_nxt.a1   = pat2d_pkg::AW'(anchor_y_r) - pat2d_pkg::AW'(in_y);
        ops_x_nxt.b1   = pat2d_pkg::BW'(coef_y_r);
        ops_y_nxt.base = pat2d_pkg::AW'(anchor_y_r);
        ops_y_nxt.a0   = pat2d_pkg::AW'(in_x) - pat2d_pkg::AW'(anchor_x_r);
        ops_y_nxt.b0   = pat2d_pkg::BW'(coef_y_r);
        ops_y_nxt.a1   = pat2d_pkg::AW'(in_y) - pat2d_pkg::AW'(anchor_y_r);
        ops_y_nxt.b1   = pat2d_pkg::BW'(coef_x_r);
      end
      pat2d_pkg::MODE_REFLECT: begin
        unique case (reflect_axis_r)
          pat2d_pkg::REFL_X_AXIS: ops_y_nxt.base = -pat2d_pkg::AW'(in_y);
          pat2d_pkg::REFL_Y_AXIS: ops_x_nxt.base = -pat2d_pkg::AW'(in_x);
          pat2d_pkg::REFL_ORIGIN: begin
            ops_x_nxt.base = -pat2d_pkg::AW'(in_x);
            ops_y_nxt.base = -pat2d_pkg::AW'(in_y);
          end
          pat2d_pkg::REFL_SWAP: begin
            ops_x_nxt.base = pat2d_pkg::AW'(in_y);
            ops_y_nxt.base = pat2d_pkg::AW'(in_x);
          end
          default: begin
          end
        endcase
      end
      pat2d_pkg::MODE_SHEAR: begin
        unique case (shear_axis_r)
          pat2d_pkg::SHEAR_X: begin
            ops_x_nxt.a0 = pat2d_pkg::AW'(in_y);
            ops_x_nxt.b0 = pat2d_pkg::BW'(coef_x_r);
          end
          pat2d_pkg::SHEAR_Y: begin
            ops_y_nxt.a0 = pat2d_pkg::AW'(in_x);
            ops_y_nxt.b0 = pat2d_pkg::BW'(coef_x_r);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // stage 4 logic: truncate toward zero, then saturate
  assign trunc_x = pat2d_pkg::TW'((s3_sum_x_r + (s3_sum_x_r[pat2d_pkg::SW-1] ?
                   pat2d_pkg::SW'(pat2d_pkg::Q_ONE_INT - 1) : '0)) >>> F);
  assign trunc_y = pat2d_pkg::TW'((s3_sum_y_r + (s3_sum_y_r[pat2d_pkg::SW-1] ?
                   pat2d_pkg::SW'(pat2d_pkg::Q_ONE_INT - 1) : '0)) >>> F);

  always_comb begin
    clip_x = 1'b1;
    clip_y = 1'b1;
    priority if (trunc_x > pat2d_pkg::SAT_HI) sat_x = C'(pat2d_pkg::SAT_HI);
    else if (trunc_x < pat2d_pkg::SAT_LO)     sat_x = C'(pat2d_pkg::SAT_LO);
    else begin
      sat_x  = C'(trunc_x);
      clip_x = 1'b0;
    end
    priority if (trunc_y > pat2d_pkg::SAT_HI) sat_y = C'(pat2d_pkg::SAT_HI);
    else if (trunc_y < pat2d_pkg::SAT_LO)     sat_y = C'(pat2d_pkg::SAT_LO);
    else begin
      sat_y  = C'(trunc_y);
      clip_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ops_x_r  <= ops_x_nxt;
      s1_ops_y_r  <= ops_y_nxt;
      // multiply
      s2_px0_r    <= s1_ops_x_r.a0 * s1_ops_x_r.b0;
      s2_px1_r    <= s1_ops_x_r.a1 * s1_ops_x_r.b1;
      s2_py0_r    <= s1_ops_y_r.a0 * s1_ops_y_r.b0;
      s2_py1_r    <= s1_ops_y_r.a1 * s1_ops_y_r.b1;
      s2_base_x_r <= s1_ops_x_r.base;
      s2_base_y_r <= s1_ops_y_r.base;
      // sum in q format
      s3_sum_x_r  <= (pat2d_pkg::SW'(s2_base_x_r) <<< F) + pat2d_pkg::SW'(s2_px0_r)
                     + pat2d_pkg::SW'(s2_px1_r);
      s3_sum_y_r  <= (pat2d_pkg::SW'(s2_base_y_r) <<< F) + pat2d_pkg::SW'(s2_py0_r)
                     + pat2d_pkg::SW'(s2_py1_r);
      out_x_r     <= sat_x;
      out_y_r     <= sat_y;
      out_clip_r  <= clip_x | clip_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pat2d_pkg::TDATA_BITS'({out_y_r, out_x_r});
  assign out_tuser  = out_clip_r;

endmodule

// File: sv/pat2d_checker.sv
// port-level checker for the point affine transform, bound to the top level
`timescale 1ns / 1ps
`include "point_affine_transform_2d_assert.svh"

module pat2d_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pat2d_pkg::TDATA_BITS-1:0] out_tdata,  // out_x, out_y
  input logic                             out_tuser,  // clipped
  input logic                             cfg_psel,
  input logic                             cfg_pready
);

  localparam int C = pat2d_pkg::COORD_BITS;

  pat2d_pkg::coord_t chk_x;
  pat2d_pkg::coord_t chk_y;
  pat2d_pkg::coord_t chk_hi;
  pat2d_pkg::coord_t chk_lo;
  logic              x_at_rail;
  logic              y_at_rail;

  assign chk_x     = out_tdata[C-1:0];
  assign chk_y     = out_tdata[2*C-1:C];
  assign chk_hi    = C'(pat2d_pkg::SAT_HI);
  assign chk_lo    = C'(pat2d_pkg::SAT_LO);
  assign x_at_rail = (chk_x == chk_hi) || (chk_x == chk_lo);
  assign y_at_rail = (chk_y == chk_hi) || (chk_y == chk_lo);

  // a held transaction keeps its payload
  `PAT2D_ASSERT_NEXT(out_hold_a, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // an empty output register never blocks the input
  `PAT2D_ASSERT_IMPL(in_ready_a, !out_tvalid, in_tready)

  // a clipped vertex has a coordinate on a rail
  `PAT2D_ASSERT_IMPL(clip_rail_a, out_tvalid && out_tuser, x_at_rail || y_at_rail)

  // the register port never inserts wait states
  `PAT2D_ASSERT_IMPL(pready_a, cfg_psel, cfg_pready)

endmodule

bind point_affine_transform_2d pat2d_checker u_pat2d_checker (.*);

// File: sim/testbench.sv
// self-checking testbench for the 2d point affine transform: directed and random vertex streams
`timescale 1ns / 1ps

module testbench;

  localparam int     LATENCY     = 4;
  localparam int     STALL_LIMIT = 2000;
  localparam int     REG_UNUSED  = 7;
  localparam int     RAND_PHASES = 35;
  localparam int     PHASE_ITEMS = 50;
  localparam longint Q_ONE       = longint'(1) << pat2d_pkg::FRAC_BITS;
  localparam longint C_MAX       = (longint'(1) << (pat2d_pkg::COORD_BITS - 1)) - 1;
  localparam longint C_MIN       = -C_MAX - 1;

  typedef struct {
    pat2d_pkg::coord_t x;
    pat2d_pkg::coord_t y;
    logic              clip;
  } point_res_t;

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [pat2d_pkg::TDATA_BITS-1:0] in_tdata    = '0;
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  logic [pat2d_pkg::TDATA_BITS-1:0] out_tdata;
  logic                             out_tuser;
  logic                             cfg_psel    = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite  = 1'b0;
  logic [pat2d_pkg::ADDR_BITS-1:0]  cfg_paddr   = '0;
  logic [pat2d_pkg::DATA_BITS-1:0]  cfg_pwdata  = '0;
  logic [pat2d_pkg::DATA_BITS-1:0]  cfg_prdata;
  logic                             cfg_pready;

  // register shadow
  logic [2:0]        cur_mode     = pat2d_pkg::MODE_TRANSLATE;
  pat2d_pkg::coord_t cur_anchor_x = '0;
  pat2d_pkg::coord_t cur_anchor_y = '0;
  pat2d_pkg::coef_t  cur_coef_x   = pat2d_pkg::coef_t'(Q_ONE);
  pat2d_pkg::coef_t  cur_coef_y   = '0;
  logic [2:0]        cur_refl     = pat2d_pkg::REFL_NONE;
  logic [1:0]        cur_shear    = pat2d_pkg::SHEAR_NONE;

  point_res_t expected_points[$];
  int         fail_count  = 0;
  int         points_sent = 0;
  int         points_seen = 0;
  int         clips_seen  = 0;
  int         reg_writes  = 0;
  int         quiet_cycles = 0;
  int         stall_left  = 0;
  bit         no_gaps     = 1'b0;

  point_affine_transform_2d dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // in_x, in_y
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // out_x, out_y
    .out_tuser  (out_tuser),   // clipped
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_coord(longint v);
    return (v > C_MAX) ? C_MAX : ((v < C_MIN) ? C_MIN : v);
  endfunction

  function automatic point_res_t transform_point(pat2d_pkg::coord_t x, pat2d_pkg::coord_t y);
    longint px, py, nx, ny, ax, ay, cx, cy, dx, dy;
    point_res_t r;
    px = x;
    py = y;
    nx = px;
    ny = py;
    ax = cur_anchor_x;
    ay = cur_anchor_y;
    cx = cur_coef_x;
    cy = cur_coef_y;
    case (cur_mode)
      pat2d_pkg::MODE_TRANSLATE: begin
        nx = px + ax;
        ny = py + ay;
      end
      pat2d_pkg::MODE_SCALE: begin
        nx = (px * cx + ax * (Q_ONE - cx)) / Q_ONE;
        ny = (py * cy + ay * (Q_ONE - cy)) / Q_ONE;
      end
      pat2d_pkg::MODE_ROTATE: begin
        dx = px - ax;
        dy = py - ay;
        nx = (ax * Q_ONE + dx * cx - dy * cy) / Q_ONE;
        ny = (ay * Q_ONE + dx * cy + dy * cx) / Q_ONE;
      end
      pat2d_pkg::MODE_REFLECT: begin
        case (cur_refl)
          pat2d_pkg::REFL_X_AXIS: ny = -py;
          pat2d_pkg::REFL_Y_AXIS: nx = -px;
          pat2d_pkg::REFL_ORIGIN: begin
            nx = -px;
            ny = -py;
          end
          pat2d_pkg::REFL_SWAP: begin
            nx = py;
            ny = px;
          end
          default: ;
        endcase
      end
      pat2d_pkg::MODE_SHEAR: begin
        if (cur_shear == pat2d_pkg::SHEAR_X) nx = (px * Q_ONE + cx * py) / Q_ONE;
        else if (cur_shear == pat2d_pkg::SHEAR_Y) ny = (cx * px + py * Q_ONE) / Q_ONE;
      end
      default: ;
    endcase
    r.clip = (clamp_coord(nx) != nx) || (clamp_coord(ny) != ny);
    r.x    = pat2d_pkg::coord_t'(clamp_coord(nx));
    r.y    = pat2d_pkg::coord_t'(clamp_coord(ny));
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // sink side back-pressure
  always @(posedge clk) begin
    if (no_gaps) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    point_res_t        want;
    pat2d_pkg::coord_t got_x, got_y;
    if (rst_n && out_tvalid && out_tready) begin
      got_x = out_tdata[pat2d_pkg::COORD_BITS-1:0];
      got_y = out_tdata[2*pat2d_pkg::COORD_BITS-1:pat2d_pkg::COORD_BITS];
      points_seen++;
      if (out_tuser) clips_seen++;
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction x=%0d y=%0d clipped=%0b",
                                  got_x, got_y, out_tuser));
      end else begin
        want = expected_points.pop_front();
        if (got_x !== want.x)
          report_mismatch($sformatf("out_x got %0d want %0d", got_x, want.x));
        if (got_y !== want.y)
          report_mismatch($sformatf("out_y got %0d want %0d", got_y, want.y));
        if (out_tuser !== want.clip)
          report_mismatch($sformatf("clipped got %0b want %0b", out_tuser, want.clip));
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(pat2d_pkg::coord_t x, pat2d_pkg::coord_t y);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
    expected_points = {expected_points, transform_point(x, y)};
    points_sent++;
  endtask

  // drain the pipe so registers can be rewritten
  task automatic settle_pipe();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(int idx, longint val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= pat2d_pkg::ADDR_BITS'(idx * 4);
    cfg_pwdata  <= val[pat2d_pkg::DATA_BITS-1:0];
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    reg_writes++;
    case (idx)
      pat2d_pkg::REG_MODE:         cur_mode     = val[2:0];
      pat2d_pkg::REG_ANCHOR_X:     cur_anchor_x = val[pat2d_pkg::COORD_BITS-1:0];
      pat2d_pkg::REG_ANCHOR_Y:     cur_anchor_y = val[pat2d_pkg::COORD_BITS-1:0];
      pat2d_pkg::REG_COEF_X:       cur_coef_x   = val[pat2d_pkg::COEF_BITS-1:0];
      pat2d_pkg::REG_COEF_Y:       cur_coef_y   = val[pat2d_pkg::COEF_BITS-1:0];
      pat2d_pkg::REG_REFLECT_AXIS: cur_refl     = val[2:0];
      pat2d_pkg::REG_SHEAR_AXIS:   cur_shear    = val[1:0];
      default: ;
    endcase
  endtask

  function automatic pat2d_pkg::coord_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return pat2d_pkg::coord_t'(C_MAX);
      1:       return pat2d_pkg::coord_t'(C_MIN);
      2, 3:    return pat2d_pkg::coord_t'(int'($urandom_range(0, 511)) - 256);
      default: return pat2d_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic pat2d_pkg::coef_t pick_coef();
    case ($urandom_range(0, 5))
      0:       return pat2d_pkg::coef_t'(C_MAX);
      1:       return pat2d_pkg::coef_t'(C_MIN);
      2:       return pat2d_pkg::coef_t'(Q_ONE + int'($urandom_range(0, 64)) - 32);
      3:       return pat2d_pkg::coef_t'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
      default: return pat2d_pkg::coef_t'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_point(pat2d_pkg::coord_t'(C_MAX), pat2d_pkg::coord_t'(C_MIN));
    send_point(pat2d_pkg::coord_t'(-1), pat2d_pkg::coord_t'(0));
    settle_pipe();
  endtask

  task automatic test_translate();
    write_reg(pat2d_pkg::REG_ANCHOR_X, C_MAX);
    write_reg(pat2d_pkg::REG_ANCHOR_Y, C_MIN);
    send_point(pat2d_pkg::coord_t'(1), pat2d_pkg::coord_t'(-1));
    send_point(pat2d_pkg::coord_t'(C_MIN), pat2d_pkg::coord_t'(C_MAX));
    send_point(pat2d_pkg::coord_t'(-1), pat2d_pkg::coord_t'(0));
    settle_pipe();
  endtask

  task automatic test_scale();
    write_reg(pat2d_pkg::REG_MODE, pat2d_pkg::MODE_SCALE);
    write_reg(pat2d_pkg::REG_COEF_X, C_MAX);
    write_reg(pat2d_pkg::REG_COEF_Y, C_MIN);
    write_reg(pat2d_pkg::REG_ANCHOR_X, -100);
    write_reg(pat2d_pkg::REG_ANCHOR_Y, 77);
    send_point(pat2d_pkg::coord_t'(C_MAX), pat2d_pkg::coord_t'(C_MIN));
    send_point(pat2d_pkg::coord_t'(3), pat2d_pkg::coord_t'(-5));
    settle_pipe();
    write_reg(pat2d_pkg::REG_COEF_X, 0);
    write_reg(pat2d_pkg::REG_COEF_Y, Q_ONE / 2);
    send_point(pat2d_pkg::coord_t'(-7), pat2d_pkg::coord_t'(-7));
    send_point(pat2d_pkg::coord_t'(1001), pat2d_pkg::coord_t'(C_MIN));
    settle_pipe();
  endtask

  task automatic test_rotate();
    write_reg(pat2d_pkg::REG_MODE, pat2d_pkg::MODE_ROTATE);
    write_reg(pat2d_pkg::REG_ANCHOR_X, 10);
    write_reg(pat2d_pkg::REG_ANCHOR_Y, -20);
    write_reg(pat2d_pkg::REG_COEF_X, 0);
    write_reg(pat2d_pkg::REG_COEF_Y, Q_ONE);
    send_point(pat2d_pkg::coord_t'(110), pat2d_pkg::coord_t'(-20));
    send_point(pat2d_pkg::coord_t'(C_MAX), pat2d_pkg::coord_t'(C_MAX));
    settle_pipe();
    write_reg(pat2d_pkg::REG_COEF_X, 2896);
    write_reg(pat2d_pkg::REG_COEF_Y, -2896);
    send_point(pat2d_pkg::coord_t'(-33), pat2d_pkg::coord_t'(47));
    send_point(pat2d_pkg::coord_t'(C_MIN), pat2d_pkg::coord_t'(C_MAX));
    settle_pipe();
  endtask

  task automatic test_reflect();
    write_reg(pat2d_pkg::REG_MODE, pat2d_pkg::MODE_REFLECT);
    for (int a = 0; a < 8; a++) begin
      if (a == 5 || a == 6) continue;
      write_reg(pat2d_pkg::REG_REFLECT_AXIS, a);
      if (a == pat2d_pkg::REFL_SWAP)
        send_point(pat2d_pkg::coord_t'(C_MIN), pat2d_pkg::coord_t'(C_MAX));
      else
        send_point(pat2d_pkg::coord_t'(C_MIN), pat2d_pkg::coord_t'(C_MIN));
      settle_pipe();
    end
  endtask

  task automatic test_shear();
    write_reg(pat2d_pkg::REG_MODE, pat2d_pkg::MODE_SHEAR);
    write_reg(pat2d_pkg::REG_COEF_X, -Q_ONE * 3 / 2);
    for (int a = 0; a < 4; a++) begin
      write_reg(pat2d_pkg::REG_SHEAR_AXIS, a);
      send_point(pat2d_pkg::coord_t'(-301), pat2d_pkg::coord_t'(C_MAX));
      settle_pipe();
    end
  endtask

  task automatic test_unused_codes();
    write_reg(pat2d_pkg::REG_MODE, 5);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_point(pat2d_pkg::coord_t'(C_MIN), pat2d_pkg::coord_t'(12345));
    settle_pipe();
    write_reg(pat2d_pkg::REG_MODE, 7);
    send_point(pat2d_pkg::coord_t'(C_MAX), pat2d_pkg::coord_t'(-1));
    settle_pipe();
  endtask

  task automatic test_random_streams();
    int m;
    for (int p = 0; p < RAND_PHASES; p++) begin
      m = $urandom_range(0, 19);
      write_reg(pat2d_pkg::REG_MODE, (m < 18) ? (m % 5) : $urandom_range(5, 7));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(pat2d_pkg::REG_ANCHOR_X,
                  pat2d_pkg::coord_t'(int'($urandom_range(0, 255)) - 128));
        write_reg(pat2d_pkg::REG_ANCHOR_Y,
                  pat2d_pkg::coord_t'(int'($urandom_range(0, 255)) - 128));
      end else begin
        write_reg(pat2d_pkg::REG_ANCHOR_X, pick_coord());
        write_reg(pat2d_pkg::REG_ANCHOR_Y, pick_coord());
      end
      write_reg(pat2d_pkg::REG_COEF_X, pick_coef());
      write_reg(pat2d_pkg::REG_COEF_Y, pick_coef());
      write_reg(pat2d_pkg::REG_REFLECT_AXIS, $urandom_range(0, 7));
      write_reg(pat2d_pkg::REG_SHEAR_AXIS, $urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, $urandom);
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send_point(pick_coord(), pick_coord());
      no_gaps = 1'b0;
      settle_pipe();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_translate();
    test_scale();
    test_rotate();
    test_reflect();
    test_shear();
    test_unused_codes();
    test_random_streams();
    settle_pipe();
    $display("sent %0d vertices over %0d register writes in all modes and axis codes",
             points_sent, reg_writes);
    $display("checked %0d results, %0d of them saturated", points_seen, clips_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
